FILE: rtl/eer_pkg.sv
package eer_pkg;

   localparam int ANGLE_BITS_DEFAULT = 32;
   localparam int STEPS = 32;
   localparam int Q_W = 34;
   localparam int V_W = 54;
   localparam int RAD_W = 48;
   localparam int TILT_W = 32;
   localparam logic [31:0] TILT_RESET = 32'd279641627;
   localparam logic signed [Q_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   // Rotation lane: Q4.30 vector, residual angle and the half-turn flip.
   typedef struct packed {
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] y;
      logic signed [Q_W-1:0] z;
      logic                  flip;
   } rot_type;

   // Vectoring lane: scaled vector, accumulated angle and the null-vector flag.
   typedef struct packed {
      logic signed [V_W-1:0] x;
      logic signed [V_W-1:0] y;
      logic [31:0]           z;
      logic                  zero;
   } vec_type;

   // One step of the restoring square root.
   typedef struct packed {
      logic [63:0] n;
      logic [63:0] root;
   } sqrt_type;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] r;
      case (i)
         0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
         3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
         6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
         9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
        12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
        15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
        18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
        21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
        24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
        27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
        30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // Folds an angle into the quarter-turn band either side of zero.
   function automatic rot_type rot_seed(input logic [31:0] ang);
      rot_type     r;
      logic [31:0] t;
      logic [31:0] a;
      t = ang + QUARTER_TURN;
      a = t[31] ? ang + HALF_TURN : ang;
      r.flip = t[31];
      r.x = CORDIC_GAIN;
      r.y = '0;
      r.z = {{(Q_W-32){a[31]}}, a};
      return r;
   endfunction

   function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
      logic signed [2*Q_W-1:0] p;
      p = a * b;
      return p[Q_W+29:30];
   endfunction

   // Scales both terms, reflects the left half-plane and flags the null vector.
   function automatic vec_type vec_seed(input logic signed [V_W-1:0] y,
                                        input logic signed [V_W-1:0] x);
      vec_type               r;
      logic signed [V_W-1:0] xs;
      logic signed [V_W-1:0] ys;
      xs = x <<< 16;
      ys = y <<< 16;
      r.zero = (x == '0) && (y == '0);
      if (xs < 0) begin
         r.x = -xs;
         r.y = -ys;
         r.z = HALF_TURN;
      end else begin
         r.x = xs;
         r.y = ys;
         r.z = '0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/eer_rot_cell.sv
module eer_rot_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  eer_pkg::rot_type d,
   output eer_pkg::rot_type q
);
   import eer_pkg::*;

   localparam logic signed [Q_W-1:0] ANG = {{(Q_W-32){1'b0}}, atan_turn(STEP)};

   rot_type q_ff;
   rot_type q_in;

   always_comb begin
      q_in.flip = d.flip;
      if (d.z >= 0) begin
         q_in.x = d.x - (d.y >>> STEP);
         q_in.y = d.y + (d.x >>> STEP);
         q_in.z = d.z - ANG;
      end else begin
         q_in.x = d.x + (d.y >>> STEP);
         q_in.y = d.y - (d.x >>> STEP);
         q_in.z = d.z + ANG;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

FILE: rtl/eer_sqrt_cell.sv
module eer_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  eer_pkg::sqrt_type d,
   output eer_pkg::sqrt_type q
);
   import eer_pkg::*;

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   sqrt_type    q_ff;
   sqrt_type    q_in;
   logic [63:0] trial;

   always_comb begin
      trial = d.root + BIT;
      if (d.n >= trial) begin
         q_in.n = d.n - trial;
         q_in.root = (d.root >> 1) + BIT;
      end else begin
         q_in.n = d.n;
         q_in.root = d.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

FILE: rtl/eer_vec_cell.sv
module eer_vec_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  eer_pkg::vec_type d,
   output eer_pkg::vec_type q
);
   import eer_pkg::*;

   localparam logic [31:0] ANG = atan_turn(STEP);

   vec_type q_ff;
   vec_type q_in;

   always_comb begin
      q_in.zero = d.zero;
      if (d.y < 0) begin
         q_in.x = d.x - (d.y >>> STEP);
         q_in.y = d.y + (d.x >>> STEP);
         q_in.z = d.z - ANG;
      end else begin
         q_in.x = d.x + (d.y >>> STEP);
         q_in.y = d.y - (d.x >>> STEP);
         q_in.z = d.z + ANG;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

FILE: rtl/ecliptic_equatorial_rotation.sv
// Rotation of a spherical position between the equatorial and ecliptic frames.
//
// An item is offered on the req_ ports and taken at a rising edge with start
// high; busy is always low, so an item may be given in every cycle and the
// sustained rate is one item per clock. Each item produces exactly one result,
// which appears on the rsp_ ports with rsp_valid high for a single cycle,
// once the item has passed every stage listed below. Results leave in the
// order the items arrived. The receiver cannot stall the block; it must take
// each result in the cycle it is shown.
// After the input stage, which is loaded on the accepting edge itself, come 32
// sine and cosine rotation steps, five multiply and combine stages, 32
// square-root steps, one seed stage and 32 arctangent vectoring steps, then the
// output register. Every stage is a register, so nothing in the datapath waits.
// The obliquity must be written by the user through csr_write_enable and
// csr_write_data only while no item is in flight; the block does not check it.
// Synchronous reset empties the pipeline (no result strobes appear until new
// items enter) and restores the default obliquity.
module ecliptic_equatorial_rotation #(
   parameter int ANGLE_BITS = eer_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [ANGLE_BITS-1:0]        req_in_longitude,
   input  logic signed [ANGLE_BITS-1:0] req_in_latitude,
   input  logic [eer_pkg::RAD_W-1:0]    req_in_radius,
   output logic                         rsp_valid,
   output logic [ANGLE_BITS-1:0]        rsp_out_longitude,
   output logic signed [ANGLE_BITS-1:0] rsp_out_latitude,
   output logic [eer_pkg::RAD_W-1:0]    rsp_out_radius,
   input  logic                         csr_write_enable,
   input  logic signed [eer_pkg::TILT_W-1:0] csr_write_data
);
   import eer_pkg::*;

   // Stage positions along the pipeline; each stage is one register.
   localparam int P1 = STEPS + 1;
   localparam int P2 = P1 + 1;
   localparam int P3 = P2 + 1;
   localparam int P4 = P3 + 1;
   localparam int P5 = P4 + 1;
   localparam int V0 = P5 + STEPS + 1;
   localparam int OUT = V0 + STEPS + 1;
   localparam int DEPTH = OUT + 1;

   // The whole pipeline advances every cycle, so the block never holds off.
   assign busy = 1'b0;

   // Obliquity register.
   logic [TILT_W-1:0] tilt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_ff <= TILT_RESET;
      end else if (csr_write_enable) begin
         tilt_ff <= csr_write_data;
      end
   end

   // Angles are brought to a 32-bit turn: narrow inputs are padded below,
   // wide ones lose their low bits.
   logic [31:0] lon_int;
   logic [31:0] lat_int;

   if (ANGLE_BITS >= 32) begin : g_in_wide
      assign lon_int = req_in_longitude[ANGLE_BITS-1 -: 32];
      assign lat_int = req_in_latitude[ANGLE_BITS-1 -: 32];
   end else begin : g_in_narrow
      assign lon_int = {req_in_longitude, {(32-ANGLE_BITS){1'b0}}};
      assign lat_int = {req_in_latitude, {(32-ANGLE_BITS){1'b0}}};
   end

   // Side band that rides with every item through the whole pipeline.
   logic             valid_ff [0:DEPTH-1];
   logic             kind_ff  [0:DEPTH-1];
   logic [RAD_W-1:0] rad_ff   [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= start;
         for (int k = 1; k < DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff[0] <= req_kind;
      rad_ff[0] <= req_in_radius;
      for (int k = 1; k < DEPTH; k++) begin
         kind_ff[k] <= kind_ff[k-1];
         rad_ff[k] <= rad_ff[k-1];
      end
   end

   // Sine and cosine of longitude, latitude and obliquity: three lanes of
   // rotation steps side by side. Position 0 is the input register.
   rot_type lon_pipe  [0:STEPS];
   rot_type lat_pipe  [0:STEPS];
   rot_type tilt_pipe [0:STEPS];
   rot_type lon_seed_ff;
   rot_type lat_seed_ff;
   rot_type tilt_seed_ff;

   always_ff @(posedge clock) begin
      lon_seed_ff <= rot_seed(lon_int);
      lat_seed_ff <= rot_seed(lat_int);
      tilt_seed_ff <= rot_seed(tilt_ff);
   end

   assign lon_pipe[0] = lon_seed_ff;
   assign lat_pipe[0] = lat_seed_ff;
   assign tilt_pipe[0] = tilt_seed_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      eer_rot_cell #(.STEP(i)) u_lon (.clock(clock), .d(lon_pipe[i]), .q(lon_pipe[i+1]));
      eer_rot_cell #(.STEP(i)) u_lat (.clock(clock), .d(lat_pipe[i]), .q(lat_pipe[i+1]));
      eer_rot_cell #(.STEP(i)) u_tilt (.clock(clock), .d(tilt_pipe[i]),
                                       .q(tilt_pipe[i+1]));
   end

   // Undo the half-turn fold before any product is taken.
   logic signed [Q_W-1:0] sl, cl, sb, cb, se, ce;

   assign sl = lon_pipe[STEPS].flip ? -lon_pipe[STEPS].y : lon_pipe[STEPS].y;
   assign cl = lon_pipe[STEPS].flip ? -lon_pipe[STEPS].x : lon_pipe[STEPS].x;
   assign sb = lat_pipe[STEPS].flip ? -lat_pipe[STEPS].y : lat_pipe[STEPS].y;
   assign cb = lat_pipe[STEPS].flip ? -lat_pipe[STEPS].x : lat_pipe[STEPS].x;
   assign se = tilt_pipe[STEPS].flip ? -tilt_pipe[STEPS].y : tilt_pipe[STEPS].y;
   assign ce = tilt_pipe[STEPS].flip ? -tilt_pipe[STEPS].x : tilt_pipe[STEPS].x;

   // First products.
   logic signed [Q_W-1:0] cbsl_ff, sbse_ff, cbcl_ff, sbce_ff, se_ff, ce_ff;

   always_ff @(posedge clock) begin
      cbsl_ff <= qmul(cb, sl);
      sbse_ff <= qmul(sb, se);
      cbcl_ff <= qmul(cb, cl);
      sbce_ff <= qmul(sb, ce);
      se_ff <= se;
      ce_ff <= ce;
   end

   // Second products; the other terms wait alongside.
   logic signed [Q_W-1:0] cbslce_ff, cbslse_ff, sbse2_ff, sbce2_ff, cbcl2_ff;

   always_ff @(posedge clock) begin
      cbslce_ff <= qmul(cbsl_ff, ce_ff);
      cbslse_ff <= qmul(cbsl_ff, se_ff);
      sbse2_ff <= sbse_ff;
      sbce2_ff <= sbce_ff;
      cbcl2_ff <= cbcl_ff;
   end

   // Combine by direction and clamp the arcsine argument to the range minus one to one.
   logic signed [Q_W:0]   v1_in;
   logic signed [Q_W:0]   w_raw;
   logic signed [31:0]    w_in;
   logic signed [Q_W:0]   v1_ff;
   logic signed [Q_W-1:0] v2_ff;
   logic signed [31:0]    w_ff;

   always_comb begin
      if (kind_ff[P2]) begin
         v1_in = {cbslce_ff[Q_W-1], cbslce_ff} - {sbse2_ff[Q_W-1], sbse2_ff};
         w_raw = {sbce2_ff[Q_W-1], sbce2_ff} + {cbslse_ff[Q_W-1], cbslse_ff};
      end else begin
         v1_in = {cbslce_ff[Q_W-1], cbslce_ff} + {sbse2_ff[Q_W-1], sbse2_ff};
         w_raw = {sbce2_ff[Q_W-1], sbce2_ff} - {cbslse_ff[Q_W-1], cbslse_ff};
      end
      if (w_raw > $signed({{(Q_W-30){1'b0}}, 1'b1, 30'd0})) begin
         w_in = 32'sh4000_0000;
      end else if (w_raw < -$signed({{(Q_W-30){1'b0}}, 1'b1, 30'd0})) begin
         w_in = -32'sh4000_0000;
      end else begin
         w_in = w_raw[31:0];
      end
   end

   always_ff @(posedge clock) begin
      v1_ff <= v1_in;
      v2_ff <= cbcl2_ff;
      w_ff <= w_in;
   end

   // Square of the clamped argument.
   logic signed [63:0]    ww_full;
   logic [61:0]           ww_ff;
   logic signed [Q_W:0]   v1d_ff;
   logic signed [Q_W-1:0] v2d_ff;
   logic signed [31:0]    wd_ff;

   assign ww_full = w_ff * w_ff;

   always_ff @(posedge clock) begin
      ww_ff <= ww_full[61:0];
      v1d_ff <= v1_ff;
      v2d_ff <= v2_ff;
      wd_ff <= w_ff;
   end

   // Radicand one minus w squared, then one root bit per step. The terms of
   // the longitude and the argument itself travel beside the root.
   sqrt_type              sq_pipe [0:STEPS];
   sqrt_type              sq_seed_ff;
   logic signed [Q_W:0]   c_v1_ff [0:STEPS];
   logic signed [Q_W-1:0] c_v2_ff [0:STEPS];
   logic signed [31:0]    c_w_ff  [0:STEPS];

   always_ff @(posedge clock) begin
      sq_seed_ff.n <= (64'd1 << 60) - {2'b00, ww_ff};
      sq_seed_ff.root <= '0;
      c_v1_ff[0] <= v1d_ff;
      c_v2_ff[0] <= v2d_ff;
      c_w_ff[0] <= wd_ff;
      for (int k = 1; k <= STEPS; k++) begin
         c_v1_ff[k] <= c_v1_ff[k-1];
         c_v2_ff[k] <= c_v2_ff[k-1];
         c_w_ff[k] <= c_w_ff[k-1];
      end
   end

   assign sq_pipe[0] = sq_seed_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_sqrt
      eer_sqrt_cell #(.STEP(i)) u_sqrt (.clock(clock), .d(sq_pipe[i]), .q(sq_pipe[i+1]));
   end

   // Arctangent seeds: longitude from the two rotated terms, latitude from
   // the argument and its root.
   vec_type lonv_pipe [0:STEPS];
   vec_type latv_pipe [0:STEPS];
   vec_type lonv_seed_ff;
   vec_type latv_seed_ff;
   logic signed [V_W-1:0] lon_y, lon_x, lat_y, lat_x;

   assign lon_y = {{(V_W-Q_W-1){c_v1_ff[STEPS][Q_W]}}, c_v1_ff[STEPS]};
   assign lon_x = {{(V_W-Q_W){c_v2_ff[STEPS][Q_W-1]}}, c_v2_ff[STEPS]};
   assign lat_y = {{(V_W-32){c_w_ff[STEPS][31]}}, c_w_ff[STEPS]};
   assign lat_x = {{(V_W-31){1'b0}}, sq_pipe[STEPS].root[30:0]};

   always_ff @(posedge clock) begin
      lonv_seed_ff <= vec_seed(lon_y, lon_x);
      latv_seed_ff <= vec_seed(lat_y, lat_x);
   end

   assign lonv_pipe[0] = lonv_seed_ff;
   assign latv_pipe[0] = latv_seed_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      eer_vec_cell #(.STEP(i)) u_lon (.clock(clock), .d(lonv_pipe[i]),
                                      .q(lonv_pipe[i+1]));
      eer_vec_cell #(.STEP(i)) u_lat (.clock(clock), .d(latv_pipe[i]),
                                      .q(latv_pipe[i+1]));
   end

   // Output register. A null vector gives an angle of zero.
   logic [31:0] out_lon_ff;
   logic [31:0] out_lat_ff;

   always_ff @(posedge clock) begin
      out_lon_ff <= lonv_pipe[STEPS].zero ? 32'd0 : lonv_pipe[STEPS].z;
      out_lat_ff <= latv_pipe[STEPS].zero ? 32'd0 : latv_pipe[STEPS].z;
   end

   // Back from the 32-bit turn to the port width.
   if (ANGLE_BITS == 32) begin : g_out_same
      assign rsp_out_longitude = out_lon_ff;
      assign rsp_out_latitude = out_lat_ff;
   end else if (ANGLE_BITS > 32) begin : g_out_wide
      assign rsp_out_longitude = {out_lon_ff, {(ANGLE_BITS-32){1'b0}}};
      assign rsp_out_latitude = {out_lat_ff, {(ANGLE_BITS-32){1'b0}}};
   end else begin : g_out_narrow
      assign rsp_out_longitude = out_lon_ff[31 -: ANGLE_BITS];
      assign rsp_out_latitude = out_lat_ff[31 -: ANGLE_BITS];
   end

   assign rsp_valid = valid_ff[OUT];
   assign rsp_out_radius = rad_ff[OUT];

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic KIND_TO_ECLIPTIC   = 1'b0;
   localparam logic KIND_TO_EQUATORIAL = 1'b1;
   localparam int   PIPE_DEPTH         = 103;
   localparam int   MAX_GAP            = 18;
   localparam int   RANDOM_ITEMS       = 1100;
   localparam longint ONE_Q30          = 64'sd1 << 30;
   localparam longint HALF_T           = 64'sd2147483648;

   localparam logic [31:0] ARCTAN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

   typedef struct {
      logic [31:0] lon;
      logic [31:0] lat;
      logic [47:0] radius;
   } position_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = 1'b0;
   logic [31:0] req_in_longitude = '0;
   logic signed [31:0] req_in_latitude = '0;
   logic [47:0] req_in_radius = '0;
   logic        rsp_valid;
   logic [31:0] rsp_out_longitude;
   logic signed [31:0] rsp_out_latitude;
   logic [47:0] rsp_out_radius;
   logic        csr_write_enable = 1'b0;
   logic signed [31:0] csr_write_data = '0;

   position_type expected_positions[$];
   logic [31:0] obliquity;
   int          error_count = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          tilts_used = 0;
   bit          no_gaps = 1'b0;

   ecliptic_equatorial_rotation dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_in_longitude(req_in_longitude),
      .req_in_latitude(req_in_latitude), .req_in_radius(req_in_radius),
      .rsp_valid(rsp_valid), .rsp_out_longitude(rsp_out_longitude),
      .rsp_out_latitude(rsp_out_latitude), .rsp_out_radius(rsp_out_radius),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Rotation CORDIC giving Q2.30 sine and cosine. Angles in the back half of
   // the circle are turned by half a turn first and the results negated.
   task automatic sine_cosine(input logic [31:0] ang, output longint s, output longint c);
      logic [31:0] shifted;
      bit     flip;
      longint x, y, z, dx, dy;
      shifted = ang + 32'h4000_0000;
      flip = shifted[31];
      if (flip) ang = ang + 32'h8000_0000;
      x = 652032874;
      y = 0;
      z = longint'($signed(ang));
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ARCTAN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ARCTAN[i]);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic longint fixmul(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   // Vectoring CORDIC; the exact null vector gives an angle of zero.
   function automatic logic [31:0] vector_angle(longint y, longint x);
      longint z, dx, dy;
      if (x == 0 && y == 0) return 32'd0;
      x = x * 65536;
      y = y * 65536;
      z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = HALF_T;
      end
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y < 0) begin
            x -= dx; y += dy; z -= longint'(ARCTAN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ARCTAN[i]);
         end
      end
      return z[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   task automatic rotate_position(input logic kind, input logic [31:0] lon,
                                  input logic [31:0] lat, input logic [47:0] radius,
                                  output position_type res);
      longint sl, cl, sb, cb, se, ce, cbsl, v1, v2, w, r;
      sine_cosine(lon, sl, cl);
      sine_cosine(lat, sb, cb);
      sine_cosine(obliquity, se, ce);
      cbsl = fixmul(cb, sl);
      v1 = fixmul(cbsl, ce);
      if (kind == KIND_TO_EQUATORIAL) v1 -= fixmul(sb, se);
      else v1 += fixmul(sb, se);
      v2 = fixmul(cb, cl);
      w = fixmul(sb, ce);
      if (kind == KIND_TO_EQUATORIAL) w += fixmul(cbsl, se);
      else w -= fixmul(cbsl, se);
      // The arcsine argument cannot leave the unit range.
      if (w > ONE_Q30) w = ONE_Q30;
      if (w < -ONE_Q30) w = -ONE_Q30;
      r = longint'(int_sqrt(longint'(ONE_Q30 * ONE_Q30 - w * w)));
      res.lon = vector_angle(v1, v2);
      res.lat = vector_angle(w, r);
      res.radius = radius;
   endtask

   // Sends one item. It is entered and left just after a falling edge, and
   // start stays high between back-to-back items so it never toggles twice
   // in one time step.
   task automatic send_item(input logic kind, input logic [31:0] lon,
                            input logic [31:0] lat, input logic [47:0] radius);
      int           gap;
      position_type res;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind = kind;
      req_in_longitude = lon;
      req_in_latitude = lat;
      req_in_radius = radius;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      rotate_position(kind, lon, lat, radius, res);
      expected_positions.push_back(res);
      items_sent++;
      @(negedge clock);
   endtask

   // Lets the pipeline empty completely before anything touches the register.
   task automatic drain_pipeline();
      start = 1'b0;
      while (expected_positions.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 8) @(negedge clock);
   endtask

   task automatic write_obliquity(input logic [31:0] value);
      drain_pipeline();
      csr_write_data = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      obliquity = value;
      tilts_used++;
   endtask

   // Corners of every field: both directions, the poles, latitudes past a
   // quarter turn, the turn boundaries of longitude and the radius extremes.
   task automatic test_directed_corners();
      logic [31:0] lons[6] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                               32'hFFFF_FFFF, 32'h1234_5678};
      logic [31:0] lats[6] = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'hFFFF_FFFF};
      for (int i = 0; i < 6; i++) begin
         send_item(KIND_TO_ECLIPTIC, lons[i], lats[i], 48'h0);
         send_item(KIND_TO_EQUATORIAL, lons[5 - i], lats[i], 48'hFFFF_FFFF_FFFF);
      end
      // With no tilt the pole of one frame is the pole of the other, which
      // drives the arctangent towards the null vector.
      write_obliquity(32'h0);
      send_item(KIND_TO_ECLIPTIC, 32'h0, 32'h4000_0000, 48'h1_0000_0000);
      send_item(KIND_TO_EQUATORIAL, 32'h0, 32'hC000_0000, 48'h1_0000_0000);
      send_item(KIND_TO_ECLIPTIC, 32'h8000_0000, 32'h0, 48'h5555_5555_5555);
      send_item(KIND_TO_EQUATORIAL, 32'h4000_0000, 32'h0, 48'hAAAA_AAAA_AAAA);
      write_obliquity(32'h4000_0000);
      send_item(KIND_TO_ECLIPTIC, 32'h4000_0000, 32'h0, 48'h0);
      send_item(KIND_TO_EQUATORIAL, 32'hC000_0000, 32'h0, 48'h0);
      write_obliquity(32'hC000_0000);
      send_item(KIND_TO_ECLIPTIC, 32'h4000_0000, 32'h0, 48'h0);
      send_item(KIND_TO_EQUATORIAL, 32'h4000_0000, 32'h0, 48'h0);
      drain_pipeline();
   endtask

   // Random positions under a series of obliquities. Most latitudes stay in
   // range, a few use every bit pattern; some stretches run with no gaps.
   task automatic test_random_positions();
      logic [31:0] tilts[6];
      logic [31:0] lat;
      logic [47:0] radius;
      tilts = '{32'd279641627, 32'hC000_0000, 32'h4000_0000, 32'h0,
                $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000, $urandom() >> 2};
      for (int p = 0; p < 6; p++) begin
         write_obliquity(tilts[p]);
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) lat = $urandom();
            else lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            radius = {$urandom(), $urandom()};
            send_item($urandom_range(0, 1), $urandom(), lat, radius);
         end
         no_gaps = 1'b0;
      end
      drain_pipeline();
   endtask

   // Each strobe is compared with the oldest queued expectation.
   always @(posedge clock) begin
      position_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_positions.size() == 0) begin
            $display("%0t: unexpected result lon %h lat %h radius %h", $time,
                     rsp_out_longitude, rsp_out_latitude, rsp_out_radius);
            error_count++;
         end else begin
            want = expected_positions.pop_front();
            if (rsp_out_longitude !== want.lon) begin
               $display("%0t: longitude expected %h actual %h", $time, want.lon,
                        rsp_out_longitude);
               error_count++;
            end
            if (rsp_out_latitude !== want.lat) begin
               $display("%0t: latitude expected %h actual %h", $time, want.lat,
                        rsp_out_latitude);
               error_count++;
            end
            if (rsp_out_radius !== want.radius) begin
               $display("%0t: radius expected %h actual %h", $time, want.radius,
                        rsp_out_radius);
               error_count++;
            end
         end
      end
   end

   initial begin
      obliquity = 32'd279641627;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_corners();
      test_random_positions();
      if (expected_positions.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  expected_positions.size());
         error_count++;
      end
      $display("Sent %0d items in both directions under %0d obliquity settings,",
               items_sent, tilts_used);
      $display("and checked %0d results.", results_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/eer_pkg.sv
rtl/eer_rot_cell.sv
rtl/eer_sqrt_cell.sv
rtl/eer_vec_cell.sv
rtl/ecliptic_equatorial_rotation.sv
sim/testbench.sv
